/* rtl/cdd_pkg.sv */
`default_nettype none

package cdd_pkg;

   localparam logic [1:0] MODE_DAY   = 2'd0;
   localparam logic [1:0] MODE_WEEK  = 2'd1;
   localparam logic [1:0] MODE_MONTH = 2'd2;
   localparam logic [1:0] MODE_YEAR  = 2'd3;

   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   localparam logic [4:0] DAYS_LONG     = 5'd31;
   localparam logic [4:0] DAYS_SHORT    = 5'd30;
   localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
   localparam logic [4:0] DAYS_FEB      = 5'd28;

   localparam int          DAYS_PER_WEEK = 7;
   localparam logic [2:0]  WEEK_LAST     = 3'(DAYS_PER_WEEK - 1);

   typedef struct packed {
      logic signed [15:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
   } date_type;

   function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month) inside
         MONTH_FEB:                                len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
         default:                                  len = DAYS_LONG;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

/* rtl/cdd_leap.sv */
`default_nettype none

module cdd_leap (
   input  wire logic signed [15:0] year,
   output logic                    leap
);

   // 25 * INV25 == 1 mod 2^16; a multiple of 25 maps to at most 65535 / 25
   localparam logic [15:0] INV25     = 16'h5C29;
   localparam logic [15:0] DIV25_MAX = 16'(65535 / 25);

   logic [15:0] mag;
   logic [15:0] prod;
   logic        div4;
   logic        div16;
   logic        div25;

   assign mag   = year[15] ? 16'(-year) : 16'(year);
   assign prod  = mag * INV25;
   assign div25 = (prod <= DIV25_MAX);
   assign div4  = (year[1:0] == 2'b00);
   assign div16 = (year[3:0] == 4'b0000);

   // divisible by 4, and not by 100 unless also by 400
   assign leap = div4 && (!div25 || div16);

endmodule

`default_nettype wire

/* rtl/cdd_step.sv */
`default_nettype none

module cdd_step (
   input  wire cdd_pkg::date_type cur,
   input  wire logic [1:0]        mode,
   input  wire logic              leap,
   input  wire logic [9:0]        amount,
   output cdd_pkg::date_type      nxt
);

   logic [3:0] prev_month;
   logic [4:0] prev_len;

   assign prev_month = cur.month - 4'd1;
   assign prev_len   = cdd_pkg::month_length(prev_month, leap);

   always_comb begin
      nxt = cur;
      case (mode) inside
         cdd_pkg::MODE_DAY, cdd_pkg::MODE_WEEK: begin
            if (cur.day > 5'd1) begin
               nxt.day = cur.day - 5'd1;
            end else if (cur.month == cdd_pkg::MONTH_JAN) begin
               nxt.year  = cur.year - 16'sd1;
               nxt.month = cdd_pkg::MONTH_DEC;
               nxt.day   = cdd_pkg::DAYS_LONG;
            end else begin
               nxt.month = prev_month;
               nxt.day   = prev_len;
            end
         end
         cdd_pkg::MODE_MONTH: begin
            // December has 31 days, so the day never needs clamping on a wrap
            if (cur.month == cdd_pkg::MONTH_JAN) begin
               nxt.year  = cur.year - 16'sd1;
               nxt.month = cdd_pkg::MONTH_DEC;
            end else begin
               nxt.month = prev_month;
               if (cur.day > prev_len) begin
                  nxt.day = prev_len;
               end
            end
         end
         default: begin
            nxt.year = cur.year - $signed({6'b0, amount});
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/calendar_date_decrementer.sv */
`default_nettype none

// A result becomes valid after the sequencer passes prep, normalise and N run steps,
// where N is the count (day and month mode), 7 * count (week mode), or 1 (year mode;
// 0 if count is 0), at one step of the shared date step unit per cycle. One transaction
// is in flight at a time, the next request taken the cycle after the result leaves.
// Reset (synchronous, active high) returns the sequencer to idle and drops any result.
module calendar_date_decrementer #(
   parameter int MAX_COUNT = 1023
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_mode,
   input  wire logic [9:0]         req_count,
   input  wire logic signed [15:0] req_start_year,
   input  wire logic [3:0]         req_start_month,
   input  wire logic [4:0]         req_start_day,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_end_year,
   output logic [3:0]              rsp_end_month,
   output logic [4:0]              rsp_end_day
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_NORM = 3'd2;
   localparam logic [2:0] ST_RUN  = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]        state_ff, state_in;
   cdd_pkg::date_type date_ff, date_in;
   logic [1:0]        mode_ff, mode_in;
   logic [9:0]        cnt_ff, cnt_in;
   logic [2:0]        week_ff, week_in;
   logic              leap_ff, leap_in;

   logic [9:0]        count_sat;
   logic [3:0]        norm_month;
   logic [4:0]        norm_len;
   cdd_pkg::date_type step_nxt;
   logic              req_take;

   cdd_leap u_leap (
      .year (date_ff.year),
      .leap (leap_in)
   );

   cdd_step u_step (
      .cur    (date_ff),
      .mode   (mode_ff),
      .leap   (leap_ff),
      .amount (cnt_ff),
      .nxt    (step_nxt)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_DONE);

   assign rsp_end_year  = date_ff.year;
   assign rsp_end_month = date_ff.month;
   assign rsp_end_day   = date_ff.day;

   always_comb begin
      if (int'(req_count) > MAX_COUNT) begin
         count_sat = 10'(MAX_COUNT);
      end else begin
         count_sat = req_count;
      end
   end

   always_comb begin
      if (date_ff.month == 4'd0) begin
         norm_month = cdd_pkg::MONTH_JAN;
      end else if (date_ff.month > cdd_pkg::MONTH_DEC) begin
         norm_month = cdd_pkg::MONTH_DEC;
      end else begin
         norm_month = date_ff.month;
      end
   end

   assign norm_len = cdd_pkg::month_length(norm_month, leap_ff);

   always_comb begin
      state_in = state_ff;
      date_in  = date_ff;
      mode_in  = mode_ff;
      cnt_in   = cnt_ff;
      week_in  = week_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               date_in.year  = req_start_year;
               date_in.month = req_start_month;
               date_in.day   = req_start_day;
               mode_in       = req_mode;
               cnt_in        = count_sat;
               state_in      = ST_PREP;
            end
         end
         ST_PREP: begin
            // wait for the leap flag of the start year
            state_in = ST_NORM;
         end
         ST_NORM: begin
            date_in.month = norm_month;
            if (date_ff.day == 5'd0) begin
               date_in.day = 5'd1;
            end else if (date_ff.day > norm_len) begin
               date_in.day = norm_len;
            end
            week_in  = '0;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               date_in = step_nxt;
               if (mode_ff == cdd_pkg::MODE_WEEK) begin
                  if (week_ff == cdd_pkg::WEEK_LAST) begin
                     week_in = '0;
                     cnt_in  = cnt_ff - 10'd1;
                  end else begin
                     week_in = week_ff + 3'd1;
                  end
               end else if (mode_ff == cdd_pkg::MODE_YEAR) begin
                  cnt_in = '0;
               end else begin
                  cnt_in = cnt_ff - 10'd1;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // leap flag is registered from year; year changes by day, week or month land in December
   always_ff @(posedge clock) begin
      date_ff <= date_in;
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      week_ff <= week_in;
      leap_ff <= leap_in;
   end

`ifndef SYNTHESIS
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !rsp_valid)
      else $error("result valid the cycle after a request transaction");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   a_run_date_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (date_ff.month >= cdd_pkg::MONTH_JAN)
         && (date_ff.month <= cdd_pkg::MONTH_DEC) && (date_ff.day != 5'd0))
      else $error("date out of range while stepping");

   a_rsp_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_month >= cdd_pkg::MONTH_JAN)
         && (rsp_end_month <= cdd_pkg::MONTH_DEC) && (rsp_end_day != 5'd0))
      else $error("result date out of range");

   a_week_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (week_ff <= cdd_pkg::WEEK_LAST))
      else $error("week day counter overran");
`endif

endmodule

`default_nettype wire
